>>> hw/rtl/xcc_pkg.sv
// Shared types and constants for the XSVF to CSVF converter.
// Used by xcc_ctrl, xcc_dpath and the top level.
package xcc_pkg;

    localparam int CNT_W = 6;

    localparam logic [7:0] OP_COMPLETE = 8'h00;
    localparam logic [7:0] OP_TDOMASK  = 8'h01;
    localparam logic [7:0] OP_SIR      = 8'h02;
    localparam logic [7:0] OP_SDR      = 8'h03;
    localparam logic [7:0] OP_RUNTEST  = 8'h04;
    localparam logic [7:0] OP_REPEAT   = 8'h07;
    localparam logic [7:0] OP_SDRSIZE  = 8'h08;
    localparam logic [7:0] OP_SDRTDO   = 8'h09;
    localparam logic [7:0] OP_SDRB     = 8'h0C;
    localparam logic [7:0] OP_SDRC     = 8'h0D;
    localparam logic [7:0] OP_SDRE     = 8'h0E;
    localparam logic [7:0] OP_STATE    = 8'h12;
    localparam logic [7:0] OP_ENDIR    = 8'h13;
    localparam logic [7:0] OP_ENDDR    = 8'h14;
    localparam logic [4:0] CMD_IDLE    = 5'h1F;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_ENDSTATE = 2'd2,
        ST_TOOBIG  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IN, S_PLAN, S_Q, S_H0, S_H1, S_RD, S_DW
    } t_state;

    typedef enum logic [1:0] {
        SRC_Q, SRC_H0, SRC_H1, SRC_MEM
    } t_src;

    typedef struct packed {
        logic             step;
        logic             load;
        t_src             src;
        logic [2:0]       qk;
        logic             rd;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic             out_free;
        logic             pq;
        logic [1:0]       ph;
        logic [CNT_W-1:0] pn;
    } t_stat;

endpackage

>>> hw/rtl/xcc_ctrl.sv
// Beat sequencer for the converter: accepts one input beat, then walks the
// emission plan. Depends on xcc_pkg.
module xcc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  xcc_pkg::t_stat i_stat,
    output xcc_pkg::t_cmd  o_cmd
);
    import xcc_pkg::*;

    t_state           r_state, n_state;
    logic [2:0]       r_k, n_k;
    logic [CNT_W-1:0] r_idx, n_idx;

    function automatic t_state after_q(input t_stat s);
        if (s.ph != 2'd0) return S_H0;
        if (s.pn != '0) return S_RD;
        return S_IN;
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IN:   if (i_in_valid) n_state = S_PLAN;
            S_PLAN: n_state = i_stat.pq ? S_Q : after_q(i_stat);
            S_Q:    if (i_stat.out_free && r_k == 3'd4) n_state = after_q(i_stat);
            S_H0: begin
                if (i_stat.out_free) begin
                    if (i_stat.ph == 2'd2) n_state = S_H1;
                    else if (i_stat.pn != '0) n_state = S_RD;
                    else n_state = S_IN;
                end
            end
            S_H1:   if (i_stat.out_free) n_state = (i_stat.pn != '0) ? S_RD : S_IN;
            S_RD:   n_state = S_DW;
            S_DW: begin
                if (i_stat.out_free) n_state = (r_idx + 1'b1 == i_stat.pn) ? S_IN : S_RD;
            end
            default: n_state = S_IN;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.src  = SRC_Q;
        o_cmd.qk   = r_k;
        o_cmd.idx  = r_idx;
        o_in_stall = 1'b1;
        n_k        = r_k;
        n_idx      = r_idx;
        case (r_state)
            S_IN: begin
                o_in_stall = 1'b0;
                o_cmd.step = i_in_valid;
            end
            S_PLAN: begin
                n_k   = '0;
                n_idx = '0;
            end
            S_Q: begin
                o_cmd.load = i_stat.out_free;
                if (i_stat.out_free) n_k = r_k + 1'b1;
            end
            S_H0: begin
                o_cmd.load = i_stat.out_free;
                o_cmd.src  = SRC_H0;
            end
            S_H1: begin
                o_cmd.load = i_stat.out_free;
                o_cmd.src  = SRC_H1;
            end
            S_RD: o_cmd.rd = 1'b1;
            S_DW: begin
                o_cmd.load = i_stat.out_free;
                o_cmd.src  = SRC_MEM;
                if (i_stat.out_free) n_idx = r_idx + 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_k     <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_idx   <= n_idx;
        end
    end

endmodule

>>> hw/rtl/xcc_dpath.sv
// Converter datapath: command state, field store, emission plan and output
// register. Depends on xcc_pkg; driven by xcc_ctrl.
module xcc_dpath #(
    parameter int MAX_FIELD_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  xcc_pkg::t_cmd         i_cmd,
    output xcc_pkg::t_stat        o_stat,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_stream_end,
    output logic [1:0]            o_status,
    output logic [4:0]            o_largest_compare_bytes
);
    import xcc_pkg::*;

    localparam int DEPTH = 2 * MAX_FIELD_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rdata;

    logic [4:0]       r_cmd_q, n_cmd_q;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_fl, n_fl;
    logic [31:0]      r_pend, n_pend;
    logic [31:0]      r_act, n_act;
    logic             r_mz, n_mz;
    logic             r_mo, n_mo;
    logic [CNT_W-1:0] r_mb, n_mb;
    logic [7:0]       r_ir, n_ir;
    logic [4:0]       r_largest, n_largest;
    logic             r_halted, n_halted;
    logic             r_any, n_any;

    logic             r_pq, n_pq;
    logic [1:0]       r_ph, n_ph;
    logic [7:0]       r_h0, n_h0, r_h1, n_h1;
    logic             r_hend, n_hend;
    t_status          r_hst, n_hst;
    logic [CNT_W-1:0] r_pn, n_pn;

    logic             we;
    logic [6:0]       widx;

    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_oe;
    t_status          r_os;
    logic [4:0]       r_ol;

    logic [29:0]      nb;
    logic [32:0]      psum;
    logic             do_fin;
    logic [4:0]       fin_cmd;
    logic             fin_any;
    logic [6:0]       c7, n7, h7, mb7;
    logic [5:0]       sir_len;

    assign psum = {1'b0, r_pend} + 33'd7;
    assign nb   = psum[32:3];

    always_comb begin
        n_cmd_q = r_cmd_q;  n_cnt = r_cnt;  n_fl = r_fl;
        n_pend = r_pend;    n_act = r_act;  n_mz = r_mz;
        n_mo = r_mo;        n_mb = r_mb;    n_ir = r_ir;
        n_largest = r_largest; n_halted = r_halted; n_any = r_any;
        n_pq = 1'b0; n_ph = 2'd0; n_h0 = '0; n_h1 = '0;
        n_hend = 1'b0; n_hst = ST_OK; n_pn = '0;
        we = 1'b0; widx = '0;
        do_fin = 1'b0; fin_cmd = r_cmd_q; fin_any = 1'b0;
        c7 = {1'b0, r_cnt}; n7 = {1'b0, r_fl}; h7 = n7 >> 1; mb7 = {1'b0, r_mb};
        sir_len = 6'(({1'b0, i_in_byte} + 9'd7) >> 3);

        if (r_halted) begin
            n_halted = 1'b1;
        end else if (r_cmd_q == CMD_IDLE) begin
            n_cnt = '0;
            if (r_mo && (i_in_byte == OP_COMPLETE || i_in_byte == OP_TDOMASK ||
                         i_in_byte == OP_SDRTDO || i_in_byte == OP_RUNTEST ||
                         i_in_byte == OP_SIR || i_in_byte == OP_SDR ||
                         i_in_byte == OP_SDRB)) begin
                n_cnt = r_cnt;
                n_halted = 1'b1; n_ph = 2'd1; n_hend = 1'b1; n_hst = ST_UNKNOWN;
            end else begin
                case (i_in_byte)
                    OP_COMPLETE: begin
                        n_halted = 1'b1; n_ph = 2'd1; n_hend = 1'b1;
                    end
                    OP_TDOMASK, OP_SDR, OP_SDRTDO: begin
                        if (nb > 30'(MAX_FIELD_BYTES)) begin
                            n_halted = 1'b1; n_ph = 2'd1; n_hend = 1'b1; n_hst = ST_TOOBIG;
                        end else begin
                            if (r_pend != r_act) begin
                                n_act = r_pend;
                                n_pq  = 1'b1;
                            end
                            n_fl    = (i_in_byte == OP_SDRTDO) ? {nb[4:0], 1'b0} : nb[5:0];
                            n_cmd_q = i_in_byte[4:0];
                            n_any   = 1'b0;
                            fin_cmd = i_in_byte[4:0];
                            do_fin  = (nb == '0);
                        end
                    end
                    OP_RUNTEST: begin
                        n_ph = 2'd1; n_h0 = OP_RUNTEST;
                        n_fl = 6'd4; n_cmd_q = i_in_byte[4:0];
                    end
                    OP_SDRSIZE: begin
                        n_fl = 6'd4; n_cmd_q = i_in_byte[4:0];
                    end
                    OP_REPEAT, OP_STATE, OP_ENDIR, OP_ENDDR, OP_SIR: begin
                        n_fl = 6'd1; n_cmd_q = i_in_byte[4:0];
                    end
                    OP_SDRB: begin
                        if (nb > 30'(DEPTH)) begin
                            n_halted = 1'b1; n_ph = 2'd1; n_hend = 1'b1; n_hst = ST_TOOBIG;
                        end else begin
                            n_act = r_pend; n_mo = 1'b1; n_mb = '0;
                            n_fl = nb[5:0]; n_cmd_q = i_in_byte[4:0];
                            fin_cmd = i_in_byte[4:0]; do_fin = (nb == '0);
                        end
                    end
                    OP_SDRC, OP_SDRE: begin
                        if (!r_mo) begin
                            n_halted = 1'b1; n_ph = 2'd1; n_hend = 1'b1; n_hst = ST_UNKNOWN;
                        end else if ({1'b0, nb} + {25'd0, r_mb} > 31'(DEPTH)) begin
                            n_halted = 1'b1; n_ph = 2'd1; n_hend = 1'b1; n_hst = ST_TOOBIG;
                        end else begin
                            n_act = r_act + r_pend;
                            n_fl = nb[5:0]; n_cmd_q = i_in_byte[4:0];
                            fin_cmd = i_in_byte[4:0]; do_fin = (nb == '0);
                        end
                    end
                    default: begin
                        n_halted = 1'b1; n_ph = 2'd1; n_hend = 1'b1; n_hst = ST_UNKNOWN;
                    end
                endcase
            end
        end else begin
            n_cnt = r_cnt + 1'b1;
            do_fin = (n_cnt >= r_fl);
            case ({3'd0, r_cmd_q})
                OP_TDOMASK: begin
                    we = 1'b1; widx = n7 - 7'd1 - c7;
                    n_any = r_any | (i_in_byte != 8'd0);
                    fin_any = n_any;
                end
                OP_SDR: begin
                    we = 1'b1; widx = n7 - 7'd1 - c7;
                end
                OP_SDRB, OP_SDRC, OP_SDRE: begin
                    we = 1'b1; widx = mb7 + n7 - 7'd1 - c7;
                end
                OP_SDRTDO: begin
                    if (c7 < h7) begin
                        we = 1'b1;
                        widx = r_mz ? (h7 - 7'd1 - c7) : 7'((h7 - 7'd1 - c7) << 1);
                    end else if (!r_mz) begin
                        we = 1'b1;
                        widx = 7'(((h7 << 1) - 7'd1 - c7) << 1) + 7'd1;
                    end
                end
                OP_RUNTEST: begin
                    n_ph = 2'd1; n_h0 = i_in_byte;
                end
                OP_ENDIR, OP_ENDDR: begin
                    if (i_in_byte != 8'd0) begin
                        do_fin = 1'b0; n_cnt = r_cnt;
                        n_halted = 1'b1; n_cmd_q = CMD_IDLE;
                        n_ph = 2'd1; n_hend = 1'b1; n_hst = ST_ENDSTATE;
                    end
                end
                OP_SDRSIZE: n_pend = {r_pend[23:0], i_in_byte};
                OP_SIR: begin
                    if (r_cnt == '0) begin
                        n_ir = i_in_byte;
                        if (sir_len > 6'(MAX_FIELD_BYTES)) begin
                            do_fin = 1'b0; n_cnt = r_cnt;
                            n_halted = 1'b1; n_cmd_q = CMD_IDLE;
                            n_ph = 2'd1; n_hend = 1'b1; n_hst = ST_TOOBIG;
                        end else begin
                            n_fl = sir_len + 6'd1;
                            do_fin = (n_cnt >= n_fl);
                        end
                    end else begin
                        we = 1'b1; widx = n7 - 7'd1 - c7;
                    end
                end
                default: ;
            endcase
        end

        if (do_fin) begin
            n_cmd_q = CMD_IDLE;
            case ({3'd0, fin_cmd})
                OP_TDOMASK: begin
                    n_mz = !fin_any;
                    if (fin_any) begin
                        if ({1'b0, n_fl} > {2'b0, r_largest}) n_largest = n_fl[4:0];
                        n_ph = 2'd1; n_h0 = OP_TDOMASK; n_pn = n_fl;
                    end
                end
                OP_SDR: begin
                    n_ph = 2'd1; n_h0 = OP_SDR; n_pn = n_fl;
                end
                OP_SDRTDO: begin
                    n_ph = 2'd1;
                    if (r_mz) begin
                        n_h0 = OP_SDR; n_pn = n_fl >> 1;
                    end else begin
                        if ((n_fl >> 1) > {1'b0, r_largest}) n_largest = 5'(n_fl >> 1);
                        n_h0 = OP_SDRTDO; n_pn = n_fl;
                    end
                end
                OP_SIR: begin
                    n_ph = 2'd2; n_h0 = OP_SIR; n_h1 = n_ir; n_pn = n_fl - 6'd1;
                end
                OP_SDRB, OP_SDRC: n_mb = r_mb + n_fl;
                OP_SDRE: begin
                    n_pq = 1'b1; n_ph = 2'd1; n_h0 = OP_SDR;
                    n_pn = r_mb + n_fl; n_mo = 1'b0; n_mb = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && we && widx < 7'(DEPTH)) r_mem[widx[AW-1:0]] <= i_in_byte;
        if (i_cmd.rd) r_rdata <= r_mem[i_cmd.idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_q <= CMD_IDLE; r_cnt <= '0; r_fl <= '0;
            r_pend <= '0; r_act <= '0; r_mz <= 1'b0; r_mo <= 1'b0;
            r_mb <= '0; r_ir <= '0; r_largest <= '0; r_halted <= 1'b0; r_any <= 1'b0;
            r_pq <= 1'b0; r_ph <= '0; r_pn <= '0;
        end else if (i_cmd.step) begin
            r_cmd_q <= n_cmd_q; r_cnt <= n_cnt; r_fl <= n_fl;
            r_pend <= n_pend; r_act <= n_act; r_mz <= n_mz; r_mo <= n_mo;
            r_mb <= n_mb; r_ir <= n_ir; r_largest <= n_largest;
            r_halted <= n_halted; r_any <= n_any;
            r_pq <= n_pq; r_ph <= n_ph; r_pn <= n_pn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_h0 <= n_h0; r_h1 <= n_h1; r_hend <= n_hend; r_hst <= n_hst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_oe <= 1'b0;
            r_os <= ST_OK;
            r_ol <= r_largest;
            case (i_cmd.src)
                SRC_Q: begin
                    case (i_cmd.qk)
                        3'd0:    r_ob <= OP_SDRSIZE;
                        3'd1:    r_ob <= r_act[31:24];
                        3'd2:    r_ob <= r_act[23:16];
                        3'd3:    r_ob <= r_act[15:8];
                        default: r_ob <= r_act[7:0];
                    endcase
                end
                SRC_H0: begin
                    r_ob <= r_h0; r_oe <= r_hend; r_os <= r_hst;
                end
                SRC_H1:  r_ob <= r_h1;
                default: r_ob <= r_rdata;
            endcase
        end
    end

    assign o_stat.out_free = !r_ov || !i_out_stall;
    assign o_stat.pq = r_pq;
    assign o_stat.ph = r_ph;
    assign o_stat.pn = r_pn;

    assign o_out_valid  = r_ov;
    assign o_out_byte   = r_ob;
    assign o_stream_end = r_oe;
    assign o_status     = r_os;
    assign o_largest_compare_bytes = r_ol;

`ifndef SYNTH
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && r_halted |=> (!r_pq && r_ph == 2'd0 && r_pn == '0))
        else $error("step after halt planned output");
    a_dump_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pn} <= 7'(DEPTH))
        else $error("dump count exceeds store depth");
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_os != ST_OK |-> r_ob == 8'd0 && r_oe)
        else $error("error beat malformed");
`endif

endmodule

>>> hw/rtl/xsvf_to_csvf_converter_top.sv
// XSVF to CSVF converter top level. Each input beat is accepted, then planned, and
// then 0 to 38 output beats follow. Size and header bytes load the output register
// directly; each field-store byte takes a registered store read, then an output load.
// Input is stalled while a command's output burst drains.
// Synchronous active-low reset clears all control state; the store is not cleared.
module xsvf_to_csvf_converter_top #(
    parameter int MAX_FIELD_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_stream_end,
    output logic [1:0] o_status,
    output logic [4:0] o_largest_compare_bytes
);
    import xcc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    xcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    xcc_dpath #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_dpath (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (cmd),
        .o_stat                  (stat),
        .i_in_byte               (i_in_byte),
        .i_out_stall             (i_out_stall),
        .o_out_valid             (o_out_valid),
        .o_out_byte              (o_out_byte),
        .o_stream_end            (o_stream_end),
        .o_status                (o_status),
        .o_largest_compare_bytes (o_largest_compare_bytes)
    );

endmodule
